/* hdl/pmct_pkg.sv */
// Package with the types and constants shared by the PS/2 mouse cursor tracker files.
`timescale 1ns / 1ps
`default_nettype none

package pmct_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned MOVE_W  = 10;
    localparam int unsigned CALC_W  = 15;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic [SIZE_W-1:0]       t_size;
    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic signed [MOVE_W-1:0] t_move;
    typedef logic signed [CALC_W-1:0] t_calc;

    localparam t_cfg_idx CFG_SCREEN_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_SCREEN_HEIGHT = 1'b1;

    localparam t_size SCREEN_WIDTH_RST  = 13'd1024;
    localparam t_size SCREEN_HEIGHT_RST = 13'd768;

    localparam int unsigned HDR_SYNC_BIT  = 3;
    localparam int unsigned HDR_XSIGN_BIT = 4;
    localparam int unsigned HDR_YSIGN_BIT = 5;
    localparam int unsigned HDR_XOVF_BIT  = 6;
    localparam int unsigned HDR_YOVF_BIT  = 7;

    localparam t_move MOVE_OVF_POS = 10'sd255;
    localparam t_move MOVE_OVF_NEG = -10'sd255;

    localparam t_calc MARGIN_X  = 15'sd8;
    localparam t_calc MARGIN_Y  = 15'sd18;
    localparam t_calc COORD_MAX = 15'sd4095;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } t_phase;

endpackage

`default_nettype wire

/* hdl/ps2_mouse_cursor_tracker_core.sv */
// Top level of the PS/2 mouse cursor tracker: packet assembly, decode and edge clamping.
// A result appears on the output register in the cycle after the third byte is accepted.
// Throughput: one byte per cycle; the decode, add and clamp fit between the phase registers
// and the result register, and the input stalls only while a held result is stalled.
// Reset (synchronous, active low): phase idle, position (0,0), no result pending,
// screen width 1024 and height 768.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_cursor_tracker_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_stall,
    input  wire logic [pmct_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                               o_res_valid,
    input  wire logic                          i_res_stall,
    output logic [pmct_pkg::COORD_W-1:0]       o_cursor_x,
    output logic [pmct_pkg::COORD_W-1:0]       o_cursor_y,
    output logic [pmct_pkg::COORD_W-1:0]       o_prev_x,
    output logic [pmct_pkg::COORD_W-1:0]       o_prev_y,
    input  wire logic                          i_cfg_we,
    input  wire pmct_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [pmct_pkg::SIZE_W-1:0]   i_cfg_data
);

    pmct_pkg::t_phase r_phase;
    pmct_pkg::t_phase n_phase;
    logic [pmct_pkg::BYTE_W-1:0] r_header;
    logic [pmct_pkg::BYTE_W-1:0] r_dx;
    pmct_pkg::t_coord r_pos_x;
    pmct_pkg::t_coord r_pos_y;
    pmct_pkg::t_size  r_width;
    pmct_pkg::t_size  r_height;
    logic             r_res_valid;
    logic             n_res_valid;
    pmct_pkg::t_coord r_cursor_x;
    pmct_pkg::t_coord r_cursor_y;
    pmct_pkg::t_coord r_prev_x;
    pmct_pkg::t_coord r_prev_y;

    logic             accept;
    logic             load_header;
    logic             load_dx;
    logic             produce;
    pmct_pkg::t_move  move_x;
    pmct_pkg::t_move  move_y;
    pmct_pkg::t_calc  sum_x;
    pmct_pkg::t_calc  sum_y;
    pmct_pkg::t_coord new_x;
    pmct_pkg::t_coord new_y;

    function automatic pmct_pkg::t_move movement(
        input logic [pmct_pkg::BYTE_W-1:0] mag,
        input logic                        neg,
        input logic                        ovf
    );
        pmct_pkg::t_move d;
        d = neg ? $signed({2'b11, mag}) : $signed({2'b00, mag});
        if (ovf) begin
            d = d + (neg ? pmct_pkg::MOVE_OVF_NEG : pmct_pkg::MOVE_OVF_POS);
        end
        return d;
    endfunction

    function automatic pmct_pkg::t_coord edge_clamp(
        input pmct_pkg::t_calc v,
        input pmct_pkg::t_size size,
        input pmct_pkg::t_calc margin
    );
        pmct_pkg::t_calc s;
        pmct_pkg::t_calc r;
        s = $signed({2'b00, size});
        r = v;
        if (r < 0) begin
            r = '0;
        end else if (r > s - margin) begin
            r = s - 15'sd1;
        end
        if (r < 0) begin
            r = '0;
        end
        if (r > pmct_pkg::COORD_MAX) begin
            r = pmct_pkg::COORD_MAX;
        end
        return r[pmct_pkg::COORD_W-1:0];
    endfunction

    assign o_rx_stall = r_res_valid & i_res_stall;
    assign accept     = i_rx_valid & ~o_rx_stall;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                pmct_pkg::PH_DX: n_phase = pmct_pkg::PH_DY;
                pmct_pkg::PH_DY: n_phase = pmct_pkg::PH_HEADER;
                default: begin
                    n_phase = i_rx_byte[pmct_pkg::HDR_SYNC_BIT] ? pmct_pkg::PH_DX
                                                                : pmct_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_comb begin
        load_header = 1'b0;
        load_dx     = 1'b0;
        produce     = 1'b0;
        if (accept) begin
            unique case (r_phase)
                pmct_pkg::PH_DX: load_dx = 1'b1;
                pmct_pkg::PH_DY: produce = 1'b1;
                default:         load_header = i_rx_byte[pmct_pkg::HDR_SYNC_BIT];
            endcase
        end
    end

    always_comb begin
        move_x = movement(r_dx, r_header[pmct_pkg::HDR_XSIGN_BIT],
                          r_header[pmct_pkg::HDR_XOVF_BIT]);
        move_y = movement(i_rx_byte, r_header[pmct_pkg::HDR_YSIGN_BIT],
                          r_header[pmct_pkg::HDR_YOVF_BIT]);
        sum_x  = $signed({3'b000, r_pos_x}) + pmct_pkg::t_calc'(move_x);
        sum_y  = $signed({3'b000, r_pos_y}) - pmct_pkg::t_calc'(move_y);
        new_x  = edge_clamp(sum_x, r_width, pmct_pkg::MARGIN_X);
        new_y  = edge_clamp(sum_y, r_height, pmct_pkg::MARGIN_Y);
    end

    assign n_res_valid = produce | (r_res_valid & i_res_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pmct_pkg::PH_HEADER;
            r_header    <= '0;
            r_dx        <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_res_valid <= n_res_valid;
            if (load_header) begin
                r_header <= i_rx_byte;
            end
            if (load_dx) begin
                r_dx <= i_rx_byte;
            end
            if (produce) begin
                r_pos_x <= new_x;
                r_pos_y <= new_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pmct_pkg::SCREEN_WIDTH_RST;
            r_height <= pmct_pkg::SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmct_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                pmct_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_cursor_x <= new_x;
            r_cursor_y <= new_y;
            r_prev_x   <= r_pos_x;
            r_prev_y   <= r_pos_y;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_cursor_x  = r_cursor_x;
    assign o_cursor_y  = r_cursor_y;
    assign o_prev_x    = r_prev_x;
    assign o_prev_y    = r_prev_y;

endmodule

`default_nettype wire

/* hdl/pmct_checker.sv */
// Port-level assertion checker for the PS/2 mouse cursor tracker and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module pmct_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_rx_valid,
    input wire logic                        o_rx_stall,
    input wire logic                        o_res_valid,
    input wire logic                        i_res_stall,
    input wire logic [pmct_pkg::COORD_W-1:0] o_cursor_x,
    input wire logic [pmct_pkg::COORD_W-1:0] o_cursor_y,
    input wire logic [pmct_pkg::COORD_W-1:0] o_prev_x,
    input wire logic [pmct_pkg::COORD_W-1:0] o_prev_y
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_cursor_x)
            && $stable(o_cursor_y) && $stable(o_prev_x) && $stable(o_prev_y))
        else $error("A stalled result transaction changed or vanished.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid && i_res_stall)
        else $error("The input stalled without a blocked result.");

    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !$past(o_res_valid && i_res_stall)
            |-> $past(i_rx_valid && !o_rx_stall))
        else $error("A new result appeared without an accepted byte.");

    a_res_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_stall && !(i_rx_valid && !o_rx_stall) |=> !o_res_valid)
        else $error("A taken result was shown again.");

endmodule

bind ps2_mouse_cursor_tracker_core pmct_checker u_pmct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx_valid),
    .o_rx_stall  (o_rx_stall),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_cursor_x  (o_cursor_x),
    .o_cursor_y  (o_cursor_y),
    .o_prev_x    (o_prev_x),
    .o_prev_y    (o_prev_y)
);

`default_nettype wire

/* dv/tb_ps2_mouse_cursor_tracker_core.sv */
// Testbench for the PS/2 mouse cursor tracker: directed and random byte streams against a packet predictor.
`timescale 1ns / 1ps

module tb_ps2_mouse_cursor_tracker_core;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT = 40;
    localparam int PHASE_BYTES = 310;
    localparam int NUM_SETTINGS = 6;

    typedef logic [pmct_pkg::BYTE_W-1:0] t_byte;

    typedef struct {
        pmct_pkg::t_coord cursor_x;
        pmct_pkg::t_coord cursor_y;
        pmct_pkg::t_coord prev_x;
        pmct_pkg::t_coord prev_y;
    } t_cursor_res;

    class t_cursor_scoreboard;
        pmct_pkg::t_phase byte_ph;
        t_byte hdr;
        t_byte dx;
        pmct_pkg::t_coord pos_x;
        pmct_pkg::t_coord pos_y;
        pmct_pkg::t_size width;
        pmct_pkg::t_size height;
        t_cursor_res expected_q[$];
        int mismatches;
        int checked;

        function new();
            byte_ph = pmct_pkg::PH_HEADER;
            hdr = '0;
            dx = '0;
            pos_x = '0;
            pos_y = '0;
            width = pmct_pkg::SCREEN_WIDTH_RST;
            height = pmct_pkg::SCREEN_HEIGHT_RST;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_size(pmct_pkg::t_cfg_idx idx, pmct_pkg::t_size value);
            if (idx == pmct_pkg::CFG_SCREEN_WIDTH) begin
                width = value;
            end else begin
                height = value;
            end
        endfunction

        function int movement(t_byte mag, bit neg, bit ovf);
            int d;
            d = int'(mag);
            if (neg) begin
                d -= 256;
            end
            if (ovf) begin
                d += neg ? -255 : 255;
            end
            return d;
        endfunction

        function pmct_pkg::t_coord clamp_edge(int v, pmct_pkg::t_size size, int margin);
            int s;
            s = int'(size);
            if (v < 0) begin
                v = 0;
            end else if (v > s - margin) begin
                v = s - 1;
            end
            if (v < 0) begin
                v = 0;
            end
            if (v > 4095) begin
                v = 4095;
            end
            return pmct_pkg::t_coord'(v);
        endfunction

        // Returns zero when the byte is a dropped header.
        function bit note_byte(t_byte b);
            t_cursor_res r;
            int nx;
            int ny;
            case (byte_ph)
                pmct_pkg::PH_DX: begin
                    dx = b;
                    byte_ph = pmct_pkg::PH_DY;
                    return 1'b1;
                end
                pmct_pkg::PH_DY: begin
                    byte_ph = pmct_pkg::PH_HEADER;
                    r.prev_x = pos_x;
                    r.prev_y = pos_y;
                    nx = int'(pos_x) + movement(dx, hdr[pmct_pkg::HDR_XSIGN_BIT],
                                                hdr[pmct_pkg::HDR_XOVF_BIT]);
                    ny = int'(pos_y) - movement(b, hdr[pmct_pkg::HDR_YSIGN_BIT],
                                                hdr[pmct_pkg::HDR_YOVF_BIT]);
                    pos_x = clamp_edge(nx, width, 8);
                    pos_y = clamp_edge(ny, height, 18);
                    r.cursor_x = pos_x;
                    r.cursor_y = pos_y;
                    expected_q.push_back(r);
                    return 1'b1;
                end
                default: begin
                    if (b[pmct_pkg::HDR_SYNC_BIT]) begin
                        hdr = b;
                        byte_ph = pmct_pkg::PH_DX;
                        return 1'b1;
                    end
                    byte_ph = pmct_pkg::PH_HEADER;
                    return 1'b0;
                end
            endcase
        endfunction

        function void check_result(t_cursor_res got);
            t_cursor_res e;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result x=%0d y=%0d px=%0d py=%0d",
                             got.cursor_x, got.cursor_y, got.prev_x, got.prev_y);
                end
                return;
            end
            e = expected_q.pop_front();
            if (got.cursor_x !== e.cursor_x || got.cursor_y !== e.cursor_y ||
                got.prev_x !== e.prev_x || got.prev_y !== e.prev_y) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on result %0d: expected x=%0d y=%0d px=%0d py=%0d,",
                             checked, e.cursor_x, e.cursor_y, e.prev_x, e.prev_y);
                    $display("    got x=%0d y=%0d px=%0d py=%0d",
                             got.cursor_x, got.cursor_y, got.prev_x, got.prev_y);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_rx_valid = 1'b0;
    logic o_rx_stall;
    t_byte i_rx_byte = '0;
    logic o_res_valid;
    logic i_res_stall = 1'b0;
    logic [pmct_pkg::COORD_W-1:0] o_cursor_x;
    logic [pmct_pkg::COORD_W-1:0] o_cursor_y;
    logic [pmct_pkg::COORD_W-1:0] o_prev_x;
    logic [pmct_pkg::COORD_W-1:0] o_prev_y;
    logic i_cfg_we = 1'b0;
    pmct_pkg::t_cfg_idx i_cfg_idx = pmct_pkg::CFG_SCREEN_WIDTH;
    logic [pmct_pkg::SIZE_W-1:0] i_cfg_data = '0;

    t_cursor_scoreboard sb = new();
    int gap_max = 18;
    int bytes_used = 0;
    int cycles = 0;
    int settings_done = 0;
    bit held = 1'b0;

    ps2_mouse_cursor_tracker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_cursor_x  (o_cursor_x),
        .o_cursor_y  (o_cursor_y),
        .o_prev_x    (o_prev_x),
        .o_prev_y    (o_prev_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_rx(input t_byte b);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_rx_stall);
        if (sb.note_byte(b)) begin
            bytes_used++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_rx_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_screen(input pmct_pkg::t_size w, input pmct_pkg::t_size h);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= pmct_pkg::CFG_SCREEN_WIDTH;
        i_cfg_data <= w;
        @(negedge i_clk);
        sb.write_size(pmct_pkg::CFG_SCREEN_WIDTH, w);
        i_cfg_idx <= pmct_pkg::CFG_SCREEN_HEIGHT;
        i_cfg_data <= h;
        @(negedge i_clk);
        sb.write_size(pmct_pkg::CFG_SCREEN_HEIGHT, h);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_done++;
    endtask

    function automatic t_byte random_move();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 8'h00;
        end else if (r < 15) begin
            return 8'hFF;
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    task automatic send_random(input int target);
        int stop_at;
        int r;
        t_byte h;
        stop_at = bytes_used + target;
        while (bytes_used < stop_at) begin
            r = $urandom_range(0, 99);
            h = t_byte'($urandom_range(0, 255)) | (t_byte'(1) << pmct_pkg::HDR_SYNC_BIT);
            if (r < 84) begin
                send_rx(h);
                send_rx(random_move());
                send_rx(random_move());
            end else if (r < 94) begin
                send_rx(t_byte'($urandom_range(0, 255)));
            end else begin
                send_rx(h);
                send_rx(random_move());
            end
        end
    endtask

    initial begin
        t_cursor_res got;
        int w;
        @(posedge i_rst_n);
        forever begin
            if (!held && sb.checked == HOLD_AT) begin
                held = 1'b1;
                w = HOLD_CYCLES;
            end else begin
                w = $urandom_range(0, gap_max);
            end
            @(negedge i_clk);
            if (w > 0) begin
                i_res_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_res_stall <= 1'b0;
            do @(posedge i_clk); while (!o_res_valid);
            got.cursor_x = o_cursor_x;
            got.cursor_y = o_cursor_y;
            got.prev_x = o_prev_x;
            got.prev_y = o_prev_y;
            sb.check_result(got);
        end
    end

    initial begin
        t_byte directed[$] = {
            8'h00, 8'hF7,
            8'h08, 8'hFF, 8'h00,
            8'h48, 8'hFF, 8'h00,
            8'h48, 8'hFF, 8'h00,
            8'h18, 8'h00, 8'h00,
            8'hF8, 8'h00, 8'h00,
            8'h28, 8'h00, 8'h01,
            8'h88, 8'h00, 8'h80,
            8'h38, 8'h00, 8'h00
        };
        pmct_pkg::t_size widths[NUM_SETTINGS];
        pmct_pkg::t_size heights[NUM_SETTINGS];
        int gaps[NUM_SETTINGS] = '{18, 0, 18, 5, 18, 0};
        int errs;
        widths[0] = 13'd16;     heights[0] = 13'd32;
        widths[1] = 13'd4096;   heights[1] = 13'd4096;
        widths[2] = 13'd8191;   heights[2] = 13'd8191;
        widths[3] = 13'd0;      heights[3] = 13'd5;
        widths[4] = pmct_pkg::t_size'($urandom_range(16, 4096));
        heights[4] = pmct_pkg::t_size'($urandom_range(32, 4096));
        widths[5] = pmct_pkg::t_size'($urandom_range(0, 8191));
        heights[5] = pmct_pkg::t_size'($urandom_range(0, 8191));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) begin
            send_rx(directed[k]);
        end
        drain();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            write_screen(widths[p], heights[p]);
            gap_max = gaps[p];
            send_random(PHASE_BYTES);
            drain();
        end

        repeat (10) @(posedge i_clk);
        errs = sb.mismatches + sb.pending();
        $display("Sent %0d packet bytes and checked %0d cursor updates over %0d screen sizes,",
                 bytes_used, sb.checked, settings_done + 1);
        $display("including a %0d-cycle output hold-off and %0d mismatches.",
                 HOLD_CYCLES, errs);
        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
